@@ hdl/frp_pkg.sv @@
// frp_pkg: shared types and constants of the passive reply parser
// token and result records, parse phase and status codes, queue depth defaults
// no dependencies
`default_nettype none

package frp_pkg;

    // default queue depths
    localparam int TOK_DEPTH_DEF = 4;
    localparam int RES_DEPTH_DEF = 2;

    // characters of interest
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DIG0  = 8'h30;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_DIG9  = 8'h39;

    // tuple layout
    localparam int                  NUM_TUPLE = 6;
    localparam int                  IDX_W     = $clog2(NUM_TUPLE);
    localparam logic [IDX_W-1:0]    LAST_NUM  = IDX_W'(NUM_TUPLE - 1);

    // line position: code digits at 0..2, separator at 3, text from 4
    localparam logic [2:0] POS_LAST_CODE = 3'd2;
    localparam logic [2:0] POS_SEP       = 3'd3;
    localparam logic [2:0] POS_SAT       = 3'd5;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_READ_ERR    = 2'd1,
        ST_NOT_PASSIVE = 2'd2,
        ST_MALFORMED   = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        PH_SKIP = 4'b0001,
        PH_NUM  = 4'b0010,
        PH_DONE = 4'b0100,
        PH_BAD  = 4'b1000
    } phase_t;

    // one classified input byte
    typedef struct packed {
        logic       fail;
        logic       lf;
        logic       nul;
        logic       digit;
        logic       comma;
        logic       space;
        logic       two;
        logic [3:0] digit_val;
    } token_t;

    // one reply result
    typedef struct packed {
        status_t     status;
        logic [31:0] addr;
        logic [15:0] port;
    } result_t;

endpackage

`default_nettype wire

@@ hdl/frp_front.sv @@
// frp_front: byte classifier and token queue
// turns each accepted byte into a token_t and buffers it for the parse stage
// depends on frp_pkg
`default_nettype none

module frp_front #(
    parameter int TOK_DEPTH = frp_pkg::TOK_DEPTH_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    output logic                 full,
    input  wire logic [7:0]      rx_byte,
    input  wire logic            rx_fail,
    output logic                 tok_valid,
    output frp_pkg::token_t      tok,
    input  wire logic            tok_take
);
    import frp_pkg::*;

    localparam int PTR_W = (TOK_DEPTH > 1) ? $clog2(TOK_DEPTH) : 1;
    localparam int CNT_W = $clog2(TOK_DEPTH + 1);

    token_t             tok_mem [TOK_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    token_t             tok_in;
    logic               wr_en;
    logic               rd_en;

    // classify
    always_comb
    begin
        tok_in           = '0;
        tok_in.fail      = rx_fail;
        tok_in.lf        = (rx_byte == CH_LF);
        tok_in.nul       = (rx_byte == CH_NUL);
        tok_in.digit     = (rx_byte >= CH_DIG0) && (rx_byte <= CH_DIG9);
        tok_in.comma     = (rx_byte == CH_COMMA);
        tok_in.space     = (rx_byte == CH_SPACE);
        tok_in.two       = (rx_byte == CH_TWO);
        tok_in.digit_val = rx_byte[3:0];
    end

    assign full      = (count_reg == CNT_W'(TOK_DEPTH));
    assign tok_valid = (count_reg != '0);
    assign tok       = tok_mem[rd_ptr_reg];
    assign wr_en     = push && !full;
    assign rd_en     = tok_take && tok_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(TOK_DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(TOK_DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
        end
        if (wr_en && !rd_en)
        begin
            count_next = CNT_W'(count_reg + 1'b1);
        end
        else if (rd_en && !wr_en)
        begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tok_mem[wr_ptr_reg] <= tok_in;
        end
    end

endmodule

`default_nettype wire

@@ hdl/frp_back.sv @@
// frp_back: reply line parser
// consumes tokens, tracks the status line and the address tuple, emits results
// depends on frp_pkg
`default_nettype none

module frp_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            tok_valid,
    input  wire frp_pkg::token_t tok,
    output logic                 tok_take,
    input  wire logic            res_room,
    output logic                 res_valid,
    output frp_pkg::result_t     res
);
    import frp_pkg::*;

    logic [2:0]         line_pos_reg, line_pos_next;
    logic               code_ok_reg, code_ok_next;
    logic               first_two_reg, first_two_next;
    logic               fourth_sp_reg, fourth_sp_next;
    logic               text_end_reg, text_end_next;
    phase_t             phase_reg, phase_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [7:0]         tuple_reg [NUM_TUPLE];

    logic               tup_we;
    logic [IDX_W-1:0]   tup_waddr;
    logic [7:0]         tup_wdata;
    logic [7:0]         tup_cur;
    phase_t             phase_end;
    logic               clear;

    assign tok_take = tok_valid && res_room;
    assign tup_cur  = tuple_reg[idx_reg];

    // phase after the end of the line's text
    always_comb
    begin
        phase_end = phase_reg;
        unique case (phase_reg)
            PH_SKIP: phase_end = PH_BAD;
            PH_NUM:  phase_end = (idx_reg >= LAST_NUM) ? PH_DONE : PH_BAD;
            PH_DONE: phase_end = PH_DONE;
            PH_BAD:  phase_end = PH_BAD;
            default: phase_end = PH_BAD;
        endcase
    end

    always_comb
    begin
        line_pos_next  = line_pos_reg;
        code_ok_next   = code_ok_reg;
        first_two_next = first_two_reg;
        fourth_sp_next = fourth_sp_reg;
        text_end_next  = text_end_reg;
        phase_next     = phase_reg;
        idx_next       = idx_reg;
        tup_we         = 1'b0;
        tup_waddr      = idx_reg;
        tup_wdata      = '0;
        res_valid      = 1'b0;
        res            = '0;
        clear          = 1'b0;

        if (tok_take)
        begin
            if (tok.fail)
            begin
                res_valid  = 1'b1;
                res.status = ST_READ_ERR;
                clear      = 1'b1;
            end
            else if (tok.lf)
            begin
                clear = 1'b1;
                if (code_ok_reg && fourth_sp_reg)
                begin
                    res_valid = 1'b1;
                    if (!first_two_reg)
                    begin
                        res.status = ST_NOT_PASSIVE;
                    end
                    else if ((text_end_reg ? phase_reg : phase_end) == PH_DONE)
                    begin
                        res.status = ST_OK;
                        res.addr   = {tuple_reg[0], tuple_reg[1], tuple_reg[2], tuple_reg[3]};
                        res.port   = {tuple_reg[4], tuple_reg[5]};
                    end
                    else
                    begin
                        res.status = ST_MALFORMED;
                    end
                end
            end
            else if (!text_end_reg)
            begin
                if (tok.nul)
                begin
                    phase_next    = phase_end;
                    text_end_next = 1'b1;
                end
                else
                begin
                    if (line_pos_reg <= POS_LAST_CODE)
                    begin
                        if (!tok.digit)
                        begin
                            code_ok_next = 1'b0;
                        end
                        if (line_pos_reg == '0)
                        begin
                            first_two_next = tok.two;
                        end
                    end
                    else if (line_pos_reg == POS_SEP)
                    begin
                        fourth_sp_next = tok.space;
                    end
                    else
                    begin
                        // tuple scan
                        unique case (phase_reg)
                            PH_SKIP:
                            begin
                                if (tok.digit)
                                begin
                                    phase_next = PH_NUM;
                                    idx_next   = '0;
                                    tup_we     = 1'b1;
                                    tup_waddr  = '0;
                                    tup_wdata  = {4'd0, tok.digit_val};
                                end
                            end
                            PH_NUM:
                            begin
                                if (tok.digit)
                                begin
                                    tup_we    = 1'b1;
                                    tup_waddr = idx_reg;
                                    // times ten, wrapping at 256
                                    tup_wdata = 8'({tup_cur, 3'd0} + {tup_cur, 1'b0}
                                                   + {4'd0, tok.digit_val});
                                end
                                else if (tok.comma)
                                begin
                                    if (idx_reg >= LAST_NUM)
                                    begin
                                        phase_next = PH_DONE;
                                    end
                                    else
                                    begin
                                        idx_next  = IDX_W'(idx_reg + 1'b1);
                                        tup_we    = 1'b1;
                                        tup_waddr = IDX_W'(idx_reg + 1'b1);
                                        tup_wdata = '0;
                                    end
                                end
                                else
                                begin
                                    phase_next = (idx_reg >= LAST_NUM) ? PH_DONE : PH_BAD;
                                end
                            end
                            PH_DONE: phase_next = PH_DONE;
                            PH_BAD:  phase_next = PH_BAD;
                            default: phase_next = PH_BAD;
                        endcase
                    end
                    if (line_pos_reg < POS_SAT)
                    begin
                        line_pos_next = 3'(line_pos_reg + 1'b1);
                    end
                end
            end
        end

        if (clear)
        begin
            line_pos_next  = '0;
            code_ok_next   = 1'b1;
            first_two_next = 1'b0;
            fourth_sp_next = 1'b0;
            text_end_next  = 1'b0;
            phase_next     = PH_SKIP;
            idx_next       = '0;
            tup_we         = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_pos_reg  <= '0;
            code_ok_reg   <= 1'b1;
            first_two_reg <= 1'b0;
            fourth_sp_reg <= 1'b0;
            text_end_reg  <= 1'b0;
            phase_reg     <= PH_SKIP;
            idx_reg       <= '0;
        end
        else
        begin
            line_pos_reg  <= line_pos_next;
            code_ok_reg   <= code_ok_next;
            first_two_reg <= first_two_next;
            fourth_sp_reg <= fourth_sp_next;
            text_end_reg  <= text_end_next;
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tup_we)
        begin
            tuple_reg[tup_waddr] <= tup_wdata;
        end
    end

endmodule

`default_nettype wire

@@ hdl/frp_out.sv @@
// frp_out: result queue
// holds finished results until the consumer pops them
// depends on frp_pkg
`default_nettype none

module frp_out #(
    parameter int RES_DEPTH = frp_pkg::RES_DEPTH_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            res_valid,
    input  wire frp_pkg::result_t res,
    output logic                 res_room,
    output logic                 empty,
    input  wire logic            pop,
    output frp_pkg::result_t     head
);
    import frp_pkg::*;

    localparam int PTR_W = (RES_DEPTH > 1) ? $clog2(RES_DEPTH) : 1;
    localparam int CNT_W = $clog2(RES_DEPTH + 1);

    result_t            res_mem [RES_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               wr_en;
    logic               rd_en;

    assign res_room = (count_reg != CNT_W'(RES_DEPTH));
    assign empty    = (count_reg == '0);
    assign head     = res_mem[rd_ptr_reg];
    assign wr_en    = res_valid && res_room;
    assign rd_en    = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(RES_DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(RES_DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
        end
        if (wr_en && !rd_en)
        begin
            count_next = CNT_W'(count_reg + 1'b1);
        end
        else if (rd_en && !wr_en)
        begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            res_mem[wr_ptr_reg] <= res;
        end
    end

endmodule

`default_nettype wire

@@ hdl/ftp_passive_reply_parser.sv @@
// ftp_passive_reply_parser: top level of the passive reply parser
// front classifier/token queue, line parser and result queue
// depends on frp_pkg, frp_front, frp_back, frp_out
//
//  channel   handshake            payload
//  -------   ------------------   -----------------------------------
//  input     push / full          rx_byte[7:0], rx_fail
//  result    empty / pop          status[1:0], server_addr[31:0],
//                                 server_port[15:0]
//
// one byte per cycle sustained while the result queue has room
// the byte that ends a result is registered in the token queue, the
// result then in the result queue, whose head drives the result ports
// reset empties both queues and returns the parser to the start of a reply
// full rises only when the token queue fills, i.e. while the result queue
// is full and the consumer holds off pop
`default_nettype none

module ftp_passive_reply_parser #(
    parameter int TOK_DEPTH = frp_pkg::TOK_DEPTH_DEF,
    parameter int RES_DEPTH = frp_pkg::RES_DEPTH_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    // byte stream in
    input  wire logic           push,
    output logic                full,
    input  wire logic [7:0]     rx_byte,
    input  wire logic           rx_fail,
    // results out
    output logic                empty,
    input  wire logic           pop,
    output logic [1:0]          status,
    output logic [31:0]         server_addr,
    output logic [15:0]         server_port
);
    import frp_pkg::*;

    // token path between classifier and parser
    logic       tok_valid;
    token_t     tok;
    logic       tok_take;

    // result path between parser and output queue
    logic       res_valid;
    result_t    res;
    logic       res_room;
    result_t    head;

    // classify bytes and buffer them
    frp_front #(
        .TOK_DEPTH (TOK_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .rx_byte   (rx_byte),
        .rx_fail   (rx_fail),
        .tok_valid (tok_valid),
        .tok       (tok),
        .tok_take  (tok_take)
    );

    // walk the reply lines, one token per cycle while results have room
    frp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (tok_valid),
        .tok       (tok),
        .tok_take  (tok_take),
        .res_room  (res_room),
        .res_valid (res_valid),
        .res       (res)
    );

    // finished results wait here for pop
    frp_out #(
        .RES_DEPTH (RES_DEPTH)
    ) u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .res_room  (res_room),
        .empty     (empty),
        .pop       (pop),
        .head      (head)
    );

    assign status      = head.status;
    assign server_addr = head.addr;
    assign server_port = head.port;

endmodule

`default_nettype wire

@@ tb/ftp_passive_reply_parser_tb.sv @@
// ftp_passive_reply_parser_tb: self-checking bench for the passive reply parser
// drives reply byte streams, predicts each result and checks it field by field
// depends on frp_pkg and ftp_passive_reply_parser
`default_nettype none

module ftp_passive_reply_parser_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import frp_pkg::*;

    // clock, reset and block ports
    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        push        = 1'b0;
    logic        full;
    logic [7:0]  rx_byte     = 8'h00;
    logic        rx_fail     = 1'b0;
    logic        empty;
    logic        pop         = 1'b0;
    logic [1:0]  status;
    logic [31:0] server_addr;
    logic [15:0] server_port;

    // results predicted but not yet seen on the result side
    result_t     expected_replies[$];
    int          mismatch_count  = 0;
    int          items_sent      = 0;

    // idling controls, changed by the test tasks
    int          tx_idle_pct     = 20;
    int          rx_idle_pct     = 20;
    int          consumer_hold   = 0;

    // bytes of the next stretch of stream: bit 8 marks a link failure
    logic [8:0]  line_bytes[$];

    // predicted parser state
    logic [2:0]        pos;
    logic              code_ok;
    logic              first_two;
    logic              sep_space;
    logic              txt_end;
    phase_t            ph;
    logic [IDX_W-1:0]  num_idx;
    logic [7:0]        tup[NUM_TUPLE];

    always #2 clk = ~clk;

    ftp_passive_reply_parser i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .rx_byte     (rx_byte),
        .rx_fail     (rx_fail),
        .empty       (empty),
        .pop         (pop),
        .status      (status),
        .server_addr (server_addr),
        .server_port (server_port)
    );

    // ------------------------------------------------------------------
    // reply predictor
    // ------------------------------------------------------------------

    function automatic bit is_dec_digit(input logic [7:0] c);
        return c >= CH_DIG0 && c <= CH_DIG9;
    endfunction

    // back to the start of a reply
    function automatic void clear_reply_state();
        pos       = 3'd0;
        code_ok   = 1'b1;
        first_two = 1'b0;
        sep_space = 1'b0;
        txt_end   = 1'b0;
        ph        = PH_SKIP;
        num_idx   = '0;
        foreach (tup[k])
            tup[k] = 8'd0;
    endfunction

    // end of line text closes the tuple like any terminating character
    function automatic void end_line_text();
        if (ph == PH_SKIP)
            ph = PH_BAD;
        else if (ph == PH_NUM)
            ph = (num_idx >= LAST_NUM) ? PH_DONE : PH_BAD;
        txt_end = 1'b1;
    endfunction

    // advance the predicted state by one accepted byte, queue any result
    function automatic void parse_reply_byte(input logic [7:0] b, input logic f);
        result_t r;
        r = '0;
        if (f)
        begin
            // link failure aborts the reply, byte value does not matter
            r.status = ST_READ_ERR;
            expected_replies.push_back(r);
            clear_reply_state();
            return;
        end
        if (b == CH_LF)
        begin
            if (!txt_end)
                end_line_text();
            // only a line with a three digit code and a space is the last one
            if (code_ok && sep_space)
            begin
                if (!first_two)
                    r.status = ST_NOT_PASSIVE;
                else if (ph == PH_DONE)
                begin
                    r.status = ST_OK;
                    r.addr   = {tup[0], tup[1], tup[2], tup[3]};
                    r.port   = {tup[4], tup[5]};
                end
                else
                    r.status = ST_MALFORMED;
                expected_replies.push_back(r);
            end
            clear_reply_state();
            return;
        end
        // bytes after a zero byte wait for the line feed
        if (txt_end)
            return;
        if (b == CH_NUL)
        begin
            end_line_text();
            return;
        end
        if (pos <= POS_LAST_CODE)
        begin
            if (!is_dec_digit(b))
                code_ok = 1'b0;
            if (pos == 3'd0)
                first_two = (b == CH_TWO);
        end
        else if (pos == POS_SEP)
            sep_space = (b == CH_SPACE);
        else
        begin
            // tuple scan from character 4 on
            case (ph)
                PH_SKIP:
                    if (is_dec_digit(b))
                    begin
                        ph      = PH_NUM;
                        num_idx = '0;
                        tup[0]  = b - CH_DIG0;
                    end
                PH_NUM:
                    if (is_dec_digit(b))
                        tup[num_idx] = tup[num_idx] * 8'd10 + (b - CH_DIG0);
                    else if (b == CH_COMMA)
                    begin
                        if (num_idx >= LAST_NUM)
                            ph = PH_DONE;
                        else
                        begin
                            num_idx      = num_idx + 1'b1;
                            tup[num_idx] = 8'd0;
                        end
                    end
                    else
                        ph = (num_idx >= LAST_NUM) ? PH_DONE : PH_BAD;
                default: ;
            endcase
        end
        if (pos < POS_SAT)
            pos = pos + 3'd1;
    endfunction

    // ------------------------------------------------------------------
    // idling, sending and checking
    // ------------------------------------------------------------------

    // mostly short gaps, now and then a long one
    function automatic int idle_length();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // one transfer on the input side; must be entered right after a rising edge
    task automatic send_item(input logic [7:0] b, input logic f);
        int gap;
        push    <= 1'b1;
        rx_byte <= b;
        rx_fail <= f;
        do
            @(posedge clk);
        while (full);
        parse_reply_byte(b, f);
        items_sent++;
        // push stays high when no gap follows, so back-to-back transfers work
        if ($urandom_range(0, 99) < tx_idle_pct)
        begin
            gap = idle_length();
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic put_str(input string s);
        for (int k = 0; k < s.len(); k++)
            line_bytes.push_back({1'b0, s[k]});
    endtask

    task automatic put_char(input logic [7:0] c);
        line_bytes.push_back({1'b0, c});
    endtask

    task automatic put_fail(input logic [7:0] c);
        line_bytes.push_back({1'b1, c});
    endtask

    // random printable text, digits optionally kept out
    task automatic put_filler(input int n, input bit no_digits);
        logic [7:0] c;
        repeat (n)
        begin
            c = 8'($urandom_range(32, 126));
            if (no_digits && is_dec_digit(c))
                c = "x";
            put_char(c);
        end
    endtask

    task automatic send_buffered();
        logic [8:0] entry;
        while (line_bytes.size() > 0)
        begin
            entry = line_bytes.pop_front();
            send_item(entry[7:0], entry[8]);
        end
    endtask

    task automatic send_line(input string s);
        put_str(s);
        send_buffered();
    endtask

    // lower push and wait until every predicted result has been seen
    task automatic pause_until_drained();
        push <= 1'b0;
        @(posedge clk);
        while (expected_replies.size() > 0)
            @(posedge clk);
    endtask

    // consumer: random pop stalls plus an optional long hold-off
    initial
    begin : result_receiver
        int stall;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (consumer_hold > 0)
            begin
                pop <= 1'b0;
                consumer_hold--;
            end
            else if (stall > 0)
            begin
                pop <= 1'b0;
                stall--;
            end
            else if ($urandom_range(0, 99) < rx_idle_pct)
            begin
                pop <= 1'b0;
                stall = idle_length() - 1;
            end
            else
                pop <= 1'b1;
        end
    end

    // compare every result transfer with the oldest prediction
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && pop && !empty)
        begin
            if (expected_replies.size() == 0)
                report_mismatch($sformatf("unexpected result status=%0d addr=%h port=%h",
                                          status, server_addr, server_port));
            else
            begin
                want = expected_replies.pop_front();
                if (status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %s",
                                              status, want.status.name()));
                if (server_addr !== want.addr)
                    report_mismatch($sformatf("server_addr %h, expected %h",
                                              server_addr, want.addr));
                if (server_port !== want.port)
                    report_mismatch($sformatf("server_port %h, expected %h",
                                              server_port, want.port));
            end
        end
    end

    // ------------------------------------------------------------------
    // reply generator for the random part
    // ------------------------------------------------------------------

    // well-formed reply with random content; broken ones get mutated
    task automatic build_reply(input bit broken);
        int n_cont;
        int n_dig;
        int at;
        n_cont = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
        // continuation lines: code plus dash, skipped by the parser
        repeat (n_cont)
        begin
            repeat (3) put_char(8'(CH_DIG0 + $urandom_range(0, 9)));
            put_char("-");
            put_filler($urandom_range(0, 15), 1'b0);
            if ($urandom_range(0, 1)) put_char("\r");
            put_char(CH_LF);
        end
        // last line code: mostly a passive reply
        if ($urandom_range(0, 99) < 80)
            put_str("227");
        else
            repeat (3) put_char(8'(CH_DIG0 + $urandom_range(0, 9)));
        put_char(CH_SPACE);
        put_filler($urandom_range(0, 12), 1'b1);
        for (int k = 0; k < NUM_TUPLE; k++)
        begin
            // empty numbers now and then, long ones to wrap
            if ($urandom_range(0, 99) < 5)
                n_dig = 0;
            else if ($urandom_range(0, 99) < 70)
                n_dig = $urandom_range(1, 3);
            else
                n_dig = $urandom_range(1, 4);
            if (k == 0 && n_dig == 0)
                n_dig = 1;
            repeat (n_dig) put_char(8'(CH_DIG0 + $urandom_range(0, 9)));
            if (k < NUM_TUPLE - 1)
                put_char(CH_COMMA);
        end
        if ($urandom_range(0, 1))
        begin
            put_char(")");
            put_filler($urandom_range(0, 6), 1'b0);
        end
        if ($urandom_range(0, 99) < 70) put_char("\r");
        put_char(CH_LF);
        if (broken)
        begin
            repeat ($urandom_range(1, 2))
            begin
                at = $urandom_range(0, line_bytes.size() - 1);
                case ($urandom_range(0, 3))
                    0: line_bytes.insert(at, {1'b0, CH_NUL});
                    1: line_bytes[at] = {1'b0, 8'($urandom_range(0, 255))};
                    2: line_bytes.insert(at, {1'b1, 8'($urandom_range(0, 255))});
                    default: line_bytes.delete(at);
                endcase
            end
        end
    endtask

    // ------------------------------------------------------------------
    // test tasks
    // ------------------------------------------------------------------

    // directed cases: good tuples, extremes, each status but the read error, and the line rules
    task automatic test_directed_replies();
        send_line("227 Entering Passive Mode (192,168,1,2,19,137)\r\n");
        send_line("227 (255,255,255,255,255,255)\n");
        send_line("227 (0,0,0,0,0,0)\n");
        // numbers wrap modulo 256
        send_line("227 =300,256,999,0,1000,65\n");
        // empty numbers count as zero
        send_line("227 1,,,,,\n");
        // multi-line reply, only the last line counts
        send_line("220-welcome\r\n227-more 9,9\r\n227 ok 10,0,0,1,4,1\r\n");
        send_line("500 Unknown command\r\n");
        send_line("150 1,2,3,4,5,6\n");
        // no digit at all
        send_line("227 no tuple here\r\n");
        send_line("227 \n");
        // missing comma, and text ending after the fifth number
        send_line("227 1,2,3 4,5,6\n");
        send_line("227 1,2,3,4,5\n");
        // short lines and bad codes never end the reply
        send_line("22\n\n2\r\n2270 1,2,3,4,5,6\n2a7 1,2,3,4,5,6\n");
        // anything after the sixth number ends the tuple
        send_line("227 1,2,3,4,5,6,7\n");
        send_line("227 (1,2,3,4,5,6)x\r\r\n");
        // zero byte ends the text, the rest of the line is ignored
        put_str("227 1,2,3,4,5,6");
        put_char(CH_NUL);
        put_str("junk,9\n");
        put_str("227 1,2");
        put_char(CH_NUL);
        put_str(",3,4,5,6\n");
        put_char("2");
        put_char(CH_NUL);
        put_str("27 1,2,3,4,5,6\n");
        put_str("227 ");
        put_char(CH_NUL);
        put_str("x\n");
        // high bytes are plain non-digits
        put_str("227 ");
        put_char(8'hFF);
        put_char(8'h80);
        put_str("1,2,3,4,5,6");
        put_char(8'hFF);
        put_char(CH_LF);
        send_buffered();
    endtask

    // link failure aborts a reply at the start, in the tuple, in the code and after a continuation line
    task automatic test_link_failure();
        put_fail(8'hFF);
        put_str("227 1,2");
        put_fail(8'h00);
        put_str("227 3,4,5,6,7,8\n");
        put_str("22");
        put_fail(CH_LF);
        put_str("7 9,8,7,6,5,4\n");
        put_str("220-banner\r\n");
        put_fail(CH_TWO);
        put_str("227 4,3,2,1,0,9\n");
        send_buffered();
    endtask

    // consumer holds off while the stream keeps coming, so the block fills
    task automatic test_full_stall();
        tx_idle_pct   = 0;
        consumer_hold = 300;
        for (int k = 0; k < 12; k++)
        begin
            if (k % 2 == 0)
                put_str("500 \n");
            else
                put_str("227 1,2,3,4,5,6\n");
        end
        send_buffered();
        tx_idle_pct = 20;
    endtask

    // producer pauses until every result is out, between whole replies
    task automatic test_drain_pause();
        for (int k = 0; k < 5; k++)
        begin
            build_reply(1'b0);
            send_buffered();
            pause_until_drained();
        end
    endtask

    // random stream: mostly good replies, some broken, some noise
    task automatic test_random_replies();
        int start;
        int kind;
        start = items_sent;
        while (items_sent - start < 800)
        begin
            // a stretch with no idling at all, then mixed idling
            if (items_sent - start < 400)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            else
            begin
                tx_idle_pct = 25;
                rx_idle_pct = 25;
            end
            kind = $urandom_range(0, 99);
            if (kind < 65)
                build_reply(1'b0);
            else if (kind < 85)
                build_reply(1'b1);
            else
            begin
                repeat ($urandom_range(1, 12))
                begin
                    if ($urandom_range(0, 49) == 0)
                        put_fail(8'($urandom_range(0, 255)));
                    else if ($urandom_range(0, 9) == 0)
                        put_char(CH_LF);
                    else
                        put_char(8'($urandom_range(0, 255)));
                end
            end
            send_buffered();
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial
    begin
        clear_reply_state();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_replies();
        test_link_failure();
        test_full_stall();
        test_drain_pause();
        test_random_replies();
        pause_until_drained();
        // then wait on to catch any stray results
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && expected_replies.size() == 0)
            $display("** ftp_passive_reply_parser: PASSED **");
        else
            $display("** ftp_passive_reply_parser: FAILED **");
        $finish;
    end

    // watchdog far beyond the slowest correct run
    initial
    begin
        #2ms;
        $display("** ftp_passive_reply_parser: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
hdl/frp_pkg.sv
hdl/frp_front.sv
hdl/frp_back.sv
hdl/frp_out.sv
hdl/ftp_passive_reply_parser.sv
tb/ftp_passive_reply_parser_tb.sv
